>>> src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)

`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

>>> src/ueflt_pkg.sv
package ueflt_pkg;

   localparam int VALUE_W = 32;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      logic                        valid;
      logic                        mark;
      logic signed [VALUE_W-1:0]   value;
   } cell_data_type;

endpackage

>>> src/ueflt_cell.sv
module ueflt_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ueflt_pkg::cell_ctl_type               ctl,
   input  logic signed [ueflt_pkg::VALUE_W-1:0]  load_value,
   input  logic                                  prev_valid,
   input  logic                                  dup_any,
   input  ueflt_pkg::cell_data_type              next_data,
   output ueflt_pkg::cell_data_type              cur_data,
   output logic                                  match
);

   logic                                 valid_ff;
   logic                                 valid_in;
   logic                                 mark_ff;
   logic                                 mark_in;
   logic signed [ueflt_pkg::VALUE_W-1:0] value_ff;
   logic signed [ueflt_pkg::VALUE_W-1:0] value_in;

   always_comb begin
      match    = ctl.load & valid_ff & (value_ff == load_value);
      valid_in = valid_ff;
      mark_in  = mark_ff;
      value_in = value_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
         mark_in  = 1'b0;
      end else if (ctl.shift) begin
         valid_in = next_data.valid;
         mark_in  = next_data.mark;
         value_in = next_data.value;
      end else if (ctl.load) begin
         if (valid_ff) begin
            mark_in = mark_ff | match;
         end else if (prev_valid) begin
            // take the new value at the first free slot
            valid_in = 1'b1;
            mark_in  = dup_any;
            value_in = load_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mark_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         mark_ff  <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cur_data.valid = valid_ff;
   assign cur_data.mark  = mark_ff;
   assign cur_data.value = value_ff;

endmodule

>>> src/unique_element_filter.sv
// Load: one item per cycle while busy is low; each value is compared in every cell at once.
// Emit: the edge that takes the last item raises busy; the chain then shifts toward cell 0
// once per cycle, dropping repeated heads, so results may have gaps; each result passes from
// cell 0 through the rsp output registers, and busy falls as the final result is registered.
// A result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset: synchronous; clears all cell valid bits and marks at once, no clearing pass.
`include "assert_macros.svh"

module unique_element_filter #(
   parameter int LIST_DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [ueflt_pkg::VALUE_W-1:0]  req_value,
   input  logic                                  req_last_item,
   output logic                                  rsp_valid,
   output logic signed [ueflt_pkg::VALUE_W-1:0]  rsp_unique_value,
   output logic                                  rsp_empty_list,
   output logic                                  rsp_final_result,
   output logic                                  rsp_overflowed
);

   localparam int LAST = LIST_DEPTH - 1;

   ueflt_pkg::state_type      state_ff;
   ueflt_pkg::state_type      state_in;
   ueflt_pkg::cell_ctl_type   ctl;
   ueflt_pkg::cell_data_type  data_vec [LIST_DEPTH];

   logic [LIST_DEPTH-1:0]     match_vec;
   logic [LIST_DEPTH-1:0]     valid_vec;
   logic [LIST_DEPTH-1:0]     unique_vec;

   logic                      accept;
   logic                      full;
   logic                      dup_any;
   logic                      any_unique;
   logic                      rest_unique;
   logic                      emit_end;
   logic                      valid_gap;

   logic                      overflow_ff;
   logic                      overflow_in;

   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic signed [ueflt_pkg::VALUE_W-1:0]  rsp_value_ff;
   logic signed [ueflt_pkg::VALUE_W-1:0]  rsp_value_in;
   logic                                  rsp_empty_ff;
   logic                                  rsp_empty_in;
   logic                                  rsp_final_ff;
   logic                                  rsp_final_in;
   logic                                  rsp_ovf_ff;
   logic                                  rsp_ovf_in;

   genvar i;
   generate
      for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
         ueflt_pkg::cell_data_type next_data;
         logic                     prev_valid;

         if (i == LAST) begin : g_tail
            assign next_data = '0;
         end else begin : g_mid
            assign next_data = data_vec[i+1];
         end

         if (i == 0) begin : g_head
            assign prev_valid = 1'b1;
         end else begin : g_body
            assign prev_valid = data_vec[i-1].valid;
         end

         ueflt_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .load_value (req_value),
            .prev_valid (prev_valid),
            .dup_any    (dup_any),
            .next_data  (next_data),
            .cur_data   (data_vec[i]),
            .match      (match_vec[i])
         );

         assign valid_vec[i]  = data_vec[i].valid;
         assign unique_vec[i] = data_vec[i].valid & ~data_vec[i].mark;
      end
   endgenerate

   assign busy        = (state_ff == ueflt_pkg::ST_EMIT);
   assign accept      = start & ~busy;
   assign full        = valid_vec[LAST];
   assign dup_any     = |match_vec;
   assign any_unique  = |unique_vec;
   assign rest_unique = |unique_vec[LIST_DEPTH-1:1];
   assign valid_gap   = |(valid_vec[LIST_DEPTH-1:1] & ~valid_vec[LIST_DEPTH-2:0]);

   always_comb begin
      state_in     = state_ff;
      ctl.load     = 1'b0;
      ctl.shift    = 1'b0;
      ctl.clear    = 1'b0;
      emit_end     = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_value_in = '0;
      rsp_empty_in = 1'b0;
      rsp_final_in = 1'b0;
      rsp_ovf_in   = overflow_ff;
      overflow_in  = overflow_ff;
      case (state_ff)
         ueflt_pkg::ST_IDLE: begin
            if (accept) begin
               ctl.load = ~full;
               if (full) begin
                  overflow_in = 1'b1;
               end
               if (req_last_item) begin
                  state_in = ueflt_pkg::ST_EMIT;
               end
            end
         end
         ueflt_pkg::ST_EMIT: begin
            if (unique_vec[0]) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = data_vec[0].value;
               emit_end     = ~rest_unique;
            end else if (!any_unique) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = 1'b1;
               emit_end     = 1'b1;
            end
            rsp_final_in = emit_end;
            if (emit_end) begin
               ctl.clear   = 1'b1;
               overflow_in = 1'b0;
               state_in    = ueflt_pkg::ST_IDLE;
            end else begin
               ctl.shift = 1'b1;
            end
         end
         default: begin
            state_in = ueflt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ueflt_pkg::ST_IDLE;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_final_ff <= rsp_final_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_unique_value = rsp_value_ff;
   assign rsp_empty_list   = rsp_empty_ff;
   assign rsp_final_result = rsp_final_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

   `ASSERT_NEVER(a_valid_contig, valid_gap, "cell valid bits not contiguous")
   `ASSERT_CLK(a_last_busy, (start && !busy && req_last_item) |=> busy, "emit not started")
   `ASSERT_CLK(a_rsp_src, rsp_valid_ff |-> $past(state_ff == ueflt_pkg::ST_EMIT), "stray result")
   `ASSERT_CLK(a_final_clear, (rsp_valid_ff && rsp_final_ff) |-> (valid_vec == '0), "not cleared")

endmodule

>>> verif/unique_element_filter_checker.sv
`timescale 1ns / 100ps

module unique_element_filter_checker #(
   parameter int LIST_DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic signed [ueflt_pkg::VALUE_W-1:0]  req_value,
   input  logic                                  req_last_item,
   input  logic                                  rsp_valid,
   input  logic signed [ueflt_pkg::VALUE_W-1:0]  rsp_unique_value,
   input  logic                                  rsp_empty_list,
   input  logic                                  rsp_final_result,
   input  logic                                  rsp_overflowed,
   output int                                    fail_count,
   output int                                    pending,
   output int                                    compared
);

   typedef struct {
      logic signed [ueflt_pkg::VALUE_W-1:0] unique_value;
      logic                                 empty_list;
      logic                                 final_result;
      logic                                 overflowed;
   } unique_result_type;

   unique_result_type                    due_results[$];
   logic signed [ueflt_pkg::VALUE_W-1:0] held_values[LIST_DEPTH];
   bit                                   seen_twice[LIST_DEPTH];
   int                                   held_count;
   bit                                   lost_items;
   int                                   mismatches;
   int                                   results_seen;

   initial begin
      fail_count   = 0;
      pending      = 0;
      compared     = 0;
      held_count   = 0;
      lost_items   = 0;
      mismatches   = 0;
      results_seen = 0;
   end

   task automatic clear_list();
      for (int i = 0; i < LIST_DEPTH; i++) seen_twice[i] = 0;
      held_count = 0;
      lost_items = 0;
   endtask

   task automatic absorb_item(input logic signed [ueflt_pkg::VALUE_W-1:0] v, input logic last);
      bit                twin;
      int                uniques;
      int                k;
      unique_result_type r;
      twin = 0;
      if (held_count >= LIST_DEPTH) begin
         lost_items = 1;
      end else begin
         for (int i = 0; i < held_count; i++) begin
            if (held_values[i] == v) begin
               seen_twice[i] = 1;
               twin = 1;
            end
         end
         held_values[held_count] = v;
         seen_twice[held_count] = twin;
         held_count++;
      end
      if (last) begin
         uniques = 0;
         for (int i = 0; i < held_count; i++) if (!seen_twice[i]) uniques++;
         if (uniques == 0) begin
            r.unique_value = '0;
            r.empty_list   = 1;
            r.final_result = 1;
            r.overflowed   = lost_items;
            due_results.insert(due_results.size(), r);
         end else begin
            k = 0;
            for (int i = 0; i < held_count; i++) begin
               if (!seen_twice[i]) begin
                  k++;
                  r.unique_value = held_values[i];
                  r.empty_list   = 0;
                  r.final_result = (k == uniques);
                  r.overflowed   = lost_items;
                  due_results.insert(due_results.size(), r);
               end
            end
         end
         clear_list();
      end
   endtask

   task automatic check_result();
      unique_result_type want;
      if (due_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: value %0d empty %b final %b overflow %b",
                     rsp_unique_value, rsp_empty_list, rsp_final_result, rsp_overflowed);
      end else begin
         want = due_results.pop_front();
         if (rsp_unique_value !== want.unique_value || rsp_empty_list !== want.empty_list ||
             rsp_final_result !== want.final_result || rsp_overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result %0d: expected value %0d empty %b final %b overflow %b",
                        results_seen, want.unique_value, want.empty_list,
                        want.final_result, want.overflowed);
               $display("result %0d: got value %0d empty %b final %b overflow %b",
                        results_seen, rsp_unique_value, rsp_empty_list,
                        rsp_final_result, rsp_overflowed);
            end
         end
      end
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_list();
         due_results.delete();
      end else begin
         if (rsp_valid) check_result();
         if (start && !busy) absorb_item(req_value, req_last_item);
      end
      fail_count <= mismatches;
      pending    <= due_results.size();
      compared   <= results_seen;
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int LIST_DEPTH  = 32;
   localparam int ITEM_TARGET = 350;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic signed [ueflt_pkg::VALUE_W-1:0] req_value = '0;
   logic                                 req_last_item = 1'b0;
   logic                                 busy;
   logic                                 rsp_valid;
   logic signed [ueflt_pkg::VALUE_W-1:0] rsp_unique_value;
   logic                                 rsp_empty_list;
   logic                                 rsp_final_result;
   logic                                 rsp_overflowed;
   int                                   fail_count;
   int                                   pending;
   int                                   compared;

   logic signed [ueflt_pkg::VALUE_W-1:0] list_buf[$];
   int                                   idle_pct = 0;
   int                                   item_count = 0;
   int                                   list_count = 0;
   int                                   overflow_lists = 0;

   always #6 clock = ~clock;

   unique_element_filter #(.LIST_DEPTH(LIST_DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_unique_value (rsp_unique_value),
      .rsp_empty_list   (rsp_empty_list),
      .rsp_final_result (rsp_final_result),
      .rsp_overflowed   (rsp_overflowed)
   );

   unique_element_filter_checker #(.LIST_DEPTH(LIST_DEPTH)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_unique_value (rsp_unique_value),
      .rsp_empty_list   (rsp_empty_list),
      .rsp_final_result (rsp_final_result),
      .rsp_overflowed   (rsp_overflowed),
      .fail_count       (fail_count),
      .pending          (pending),
      .compared         (compared)
   );

   task automatic send_item(input logic signed [ueflt_pkg::VALUE_W-1:0] v, input bit last);
      int gap;
      gap = 0;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 40) gap++;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start         <= 1'b1;
      req_value     <= v;
      req_last_item <= last;
      do @(posedge clock); while (busy);
      item_count++;
   endtask

   task automatic send_list();
      for (int i = 0; i < list_buf.size(); i++) send_item(list_buf[i], i == list_buf.size() - 1);
      list_count++;
      if (list_buf.size() > LIST_DEPTH) overflow_lists++;
   endtask

   // hold off until every expected transfer has been seen
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int                                   len;
      int                                   sel;
      int                                   mix;
      int                                   pool_n;
      logic signed [ueflt_pkg::VALUE_W-1:0] pool[4];
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      list_buf = '{32'sh7FFF_FFFF};
      send_list();
      list_buf = '{32'sh8000_0000, 32'sh8000_0000};
      send_list();
      list_buf = '{32'shFFFF_FFFF, 32'sd0, 32'shFFFF_FFFF, 32'sd1, 32'sh5555_5555};
      send_list();
      list_buf = '{32'sd5, 32'sd5, 32'sd5};
      send_list();
      list_buf = '{32'shAAAA_AAAA, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0};
      send_list();
      drain();
      list_buf = '{32'sd7, 32'sd8, 32'sd7, 32'sd9, 32'sd8};
      send_list();

      while (item_count < ITEM_TARGET) begin
         case (item_count * 3 / ITEM_TARGET)
            0: idle_pct = 0;
            1: idle_pct = 82;
            default: idle_pct = 17;
         endcase
         sel = $urandom_range(9);
         if (sel < 6) len = $urandom_range(1, 8);
         else if (sel < 8) len = $urandom_range(9, LIST_DEPTH - 1);
         else if (sel == 8) len = LIST_DEPTH;
         else len = LIST_DEPTH + $urandom_range(1, 6);
         for (int k = 0; k < 4; k++) begin
            case ($urandom_range(5))
               0: pool[k] = 32'sh8000_0000;
               1: pool[k] = 32'sh7FFF_FFFF;
               2: pool[k] = '0;
               3: pool[k] = '1;
               default: pool[k] = $urandom;
            endcase
         end
         pool_n = $urandom_range(1, 4);
         mix = $urandom_range(3);
         list_buf.delete();
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(3) < mix) list_buf.insert(list_buf.size(), $urandom);
            else list_buf.insert(list_buf.size(), pool[$urandom_range(pool_n - 1)]);
         end
         if ($urandom_range(5) == 0) drain();
         send_list();
      end

      drain();
      repeat (LIST_DEPTH + 8) @(posedge clock);
      $display("covered %0d lists, %0d items, %0d lists past store capacity",
               list_count, item_count, overflow_lists);
      $display("%0d results compared with sender idling at 0, 82 and 17 percent",
               compared);
      if (fail_count == 0 && pending == 0) begin
         $display("unique_element_filter test passed");
      end else begin
         $display("unique_element_filter test failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("unique_element_filter test failed");
      $finish;
   end

endmodule
